[rtl/core/sfm_pkg.sv]
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the serial mouse report engine
// Function codes, command characters, register indexes, engine states, FIFO
// control beat and the motion helpers (magnitude, take-off, saturating add).
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int ACC_W  = 20;
  localparam int DELTA_W = 12;
  localparam logic [5:0] MOTION_CAP = 6'h3F;
  localparam logic [3:0] DEV_REVISION = 4'h0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 20'sh7FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 20'sh80000;

  // function codes
  localparam logic [1:0] FN_CMD   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_EVENT = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  // host command characters
  localparam logic [7:0] CMD_INCR   = 8'h52;
  localparam logic [7:0] CMD_PROMPT = 8'h44;
  localparam logic [7:0] CMD_POLL   = 8'h50;
  localparam logic [7:0] CMD_TEST   = 8'h54;

  // register indexes
  localparam logic [1:0] REG_SYNC_MASK = 2'd0;
  localparam logic [1:0] REG_TEST_ID   = 2'd1;
  localparam logic [1:0] REG_TEST_TYPE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_READ,
    ST_EVENT,
    ST_TEST,
    ST_HDR,
    ST_MX,
    ST_MY,
    ST_DONE
  } sfm_state_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } sfm_fifo_ctl_t;

  // |v| capped at the motion limit
  function automatic logic [5:0] mag6(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] absv;
    absv = v[ACC_W-1] ? (~v + 1'b1) : v;
    if (absv >= {{(ACC_W-6){1'b0}}, MOTION_CAP}) begin
      return MOTION_CAP;
    end
    return absv[5:0];
  endfunction

  // accumulator after its magnitude is taken off toward zero
  function automatic logic signed [ACC_W-1:0] take_mag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = {{(ACC_W-6){1'b0}}, mag6(v)};
    if (v > 0) begin
      return v - $signed(m);
    end
    return v + $signed(m);
  endfunction

  // saturating accumulate of one motion delta
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [DELTA_W-1:0] d);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

[rtl/core/sfm_fifo.sv]
// ----------------------------------------------------------------------------
// sfm_fifo: report byte FIFO
// Synchronous byte memory with read pointer, write pointer and fill count.
// Read data is the registered entry at the read pointer.
// ----------------------------------------------------------------------------
module sfm_fifo
  import sfm_pkg::*;
#(
  parameter int FIFO_DEPTH = 128,
  localparam int PtrW = $clog2(FIFO_DEPTH),
  localparam int CntW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sfm_fifo_ctl_t       ctl,
  output logic [7:0]          rdata,
  output logic [CntW-1:0]     count,
  output logic                full
);

  logic [7:0]      mem [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            push_ok;
  logic            pop_ok;

  assign full    = (count == CntW'(FIFO_DEPTH));
  assign push_ok = ctl.push && !full;
  assign pop_ok  = ctl.pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= ctl.wdata;
    end
    rdata <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FIFO_DEPTH))
    else $error("fifo count above depth");

  a_full_push_hold: assert property (@(posedge clk) disable iff (rst)
    full && ctl.push && !ctl.pop && !ctl.clear |=> full)
    else $error("push into full fifo changed count");

endmodule

[rtl/core/serial_mouse_report_engine.sv]
// ----------------------------------------------------------------------------
// serial_mouse_report_engine: serial mouse protocol engine with report FIFO
// Host commands, byte reads and mouse events over a start/busy port; motion
// reports and self-test bytes are queued in an on-chip byte memory.
// ----------------------------------------------------------------------------
// Usage: raise start with func and its operands while busy is low; the beat is
// taken on that edge and busy rises. Exactly one result comes back, on done,
// valid for that single cycle only; the receiver cannot hold it off. It
// carries read_data/read_valid (a popped byte on a read, else zero) and
// fifo_level (bytes held after the item, low 8 bits).
// Sequence: a nop goes straight to done; a read passes through the read state,
// a command through the command state, which clears the FIFO, and an event
// through the event state. Self test then writes the ID byte, the type byte
// and two zero bytes from the test state. Any item that generates motion
// reports writes each as a header, X and Y byte, one FIFO write per cycle
// through the single memory write port. busy stays high through the done
// cycle, so the next beat is taken the cycle after done.
// Configuration (cfg_we/cfg_index/cfg_data) lands on the edge where cfg_we is
// high; write it only while busy is low.
// ----------------------------------------------------------------------------
module serial_mouse_report_engine
  import sfm_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic [7:0]                cmd_byte,
  input  logic signed [DELTA_W-1:0] delta_x,
  input  logic signed [DELTA_W-1:0] delta_y,
  input  logic                      left_button,
  input  logic                      middle_button,
  input  logic                      right_button,
  // result
  output logic                      done,
  output logic [7:0]                read_data,
  output logic                      read_valid,
  output logic [7:0]                fifo_level,
  // configuration
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [7:0]                cfg_data
);

  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  // config registers
  logic [7:0] sync_bit_mask;
  logic [7:0] test_id_byte;
  logic [7:0] test_type_byte;

  // device state
  sfm_state_t              state, state_next;
  logic                    incr_mode, incr_mode_next;
  logic signed [ACC_W-1:0] accum_x, accum_x_next;
  logic signed [ACC_W-1:0] accum_y, accum_y_next;
  logic [2:0]              btn, btn_next;          // {L, M, R}
  logic [1:0]              tcnt, tcnt_next;        // self-test byte index

  // latched beat
  logic [1:0]                func_q;
  logic [7:0]                cmd_q;
  logic signed [DELTA_W-1:0] dx_q;
  logic signed [DELTA_W-1:0] dy_q;
  logic [2:0]                btn_q;

  // result registers
  logic [7:0] rdata_r, rdata_next;
  logic       rvalid_r, rvalid_next;

  // FIFO
  sfm_fifo_ctl_t   fctl;
  logic [7:0]      f_rdata;
  logic [CntW-1:0] f_count;
  logic            f_full;
  logic [CntW+7:0] level_ext;

  logic                    accept;
  logic                    changed;
  logic signed [ACC_W-1:0] y_after;

  sfm_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fctl),
    .rdata (f_rdata),
    .count (f_count),
    .full  (f_full)
  );

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign done       = (state == ST_DONE);
  assign read_data  = rdata_r;
  assign read_valid = rvalid_r;
  assign level_ext  = {8'd0, f_count};
  assign fifo_level = level_ext[7:0];

  // an event with no motion and the same buttons is dropped
  assign changed = !(dx_q == '0 && dy_q == '0 && btn_q == btn);
  assign y_after = take_mag(accum_y);

  always_comb begin
    state_next     = state;
    incr_mode_next = incr_mode;
    accum_x_next   = accum_x;
    accum_y_next   = accum_y;
    btn_next       = btn;
    tcnt_next      = tcnt;
    rdata_next     = rdata_r;
    rvalid_next    = rvalid_r;
    fctl           = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          rdata_next  = 8'd0;
          rvalid_next = 1'b0;
          case (func)
            FN_CMD:   state_next = ST_CMD;
            FN_READ:  state_next = ST_READ;
            FN_EVENT: state_next = ST_EVENT;
            default:  state_next = ST_DONE;
          endcase
        end
      end

      ST_CMD: begin
        fctl.clear = 1'b1;
        state_next = ST_DONE;
        case (cmd_q)
          CMD_INCR:   incr_mode_next = 1'b1;
          CMD_PROMPT: incr_mode_next = 1'b0;
          CMD_POLL: begin
            incr_mode_next = 1'b0;
            state_next     = ST_HDR;
          end
          CMD_TEST: begin
            incr_mode_next = 1'b0;
            accum_x_next   = '0;
            accum_y_next   = '0;
            btn_next       = 3'b000;
            tcnt_next      = 2'd0;
            state_next     = ST_TEST;
          end
          default: ;
        endcase
      end

      ST_TEST: begin
        fctl.push = 1'b1;
        case (tcnt)
          2'd0:    fctl.wdata = test_id_byte | sync_bit_mask | {4'd0, DEV_REVISION};
          2'd1:    fctl.wdata = test_type_byte;
          default: fctl.wdata = 8'd0;
        endcase
        tcnt_next = tcnt + 1'b1;
        if (tcnt == 2'd3) begin
          state_next = ST_DONE;
        end
      end

      ST_READ: begin
        if (f_count != '0) begin
          fctl.pop    = 1'b1;
          rdata_next  = f_rdata;
          rvalid_next = 1'b1;
        end
        state_next = ST_DONE;
      end

      ST_EVENT: begin
        state_next = ST_DONE;
        if (changed) begin
          accum_x_next = sat_add(accum_x, dx_q);
          accum_y_next = sat_add(accum_y, dy_q);
          btn_next     = btn_q;
          if (incr_mode) begin
            state_next = ST_HDR;
          end
        end
      end

      // report header; a full FIFO here ends generation, accumulators kept
      ST_HDR: begin
        if (f_full) begin
          state_next = ST_DONE;
        end else begin
          fctl.push  = 1'b1;
          fctl.wdata = sync_bit_mask |
                       {3'd0, (accum_x > 0), accum_y[ACC_W-1], btn};
          state_next = ST_MX;
        end
      end

      ST_MX: begin
        fctl.push    = 1'b1;
        fctl.wdata   = {2'd0, mag6(accum_x)};
        accum_x_next = take_mag(accum_x);
        state_next   = ST_MY;
      end

      // repeat while both remain nonzero, else clear both
      ST_MY: begin
        fctl.push  = 1'b1;
        fctl.wdata = {2'd0, mag6(accum_y)};
        if (accum_x != '0 && y_after != '0) begin
          accum_y_next = y_after;
          state_next   = ST_HDR;
        end else begin
          accum_x_next = '0;
          accum_y_next = '0;
          state_next   = ST_DONE;
        end
      end

      ST_DONE: state_next = ST_IDLE;

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      incr_mode <= 1'b0;
      accum_x   <= '0;
      accum_y   <= '0;
      btn       <= 3'b000;
      tcnt      <= 2'd0;
      rvalid_r  <= 1'b0;
    end else begin
      incr_mode <= incr_mode_next;
      accum_x   <= accum_x_next;
      accum_y   <= accum_y_next;
      btn       <= btn_next;
      tcnt      <= tcnt_next;
      rvalid_r  <= rvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_next;
    if (accept) begin
      func_q <= func;
      cmd_q  <= cmd_byte;
      dx_q   <= delta_x;
      dy_q   <= delta_y;
      btn_q  <= {left_button, middle_button, right_button};
    end
  end

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_bit_mask  <= 8'h80;
      test_id_byte   <= 8'h20;
      test_type_byte <= 8'h12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_MASK: sync_bit_mask  <= cfg_data;
        REG_TEST_ID:   test_id_byte   <= cfg_data;
        REG_TEST_TYPE: test_type_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after done");

  a_full_keeps_accum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HDR) && f_full |=> done && $stable(accum_x) && $stable(accum_y))
    else $error("full fifo at report start changed accumulators");

  a_read_func: assert property (@(posedge clk) disable iff (rst)
    done && read_valid |-> func_q == FN_READ)
    else $error("byte returned for a non-read beat");

endmodule
